// ===== design/ppid_pkg.sv =====
// Package for the preset position PID loop: widths, preset target tables,
// configuration register codes and reset values, and the word types shared
// by the top level and the drive pipeline. Depends on nothing.
package ppid_pkg;

    // Field and state widths
    localparam int READING_W = 12;
    localparam int ERR_W     = 13;
    localparam int DIFF_W    = 14;
    localparam int SUM_W     = 40;
    localparam int GAIN_W    = 24;
    localparam int DRIVE_W   = 16;
    localparam int CNT_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Preset tables: five angles per set, and the default number of entries in use
    localparam int PRESET_TABLE_LEN = 5;
    localparam int PRESET_COUNT     = 5;

    typedef logic [READING_W-1:0] t_tgt_tab [0:PRESET_TABLE_LEN-1];

    // Target reading for each preset angle: trunc(1880 - 16.4 * angle).
    // High set angles are 53, 40, 40, 45, 40; low set angles are 35, 28, 25, 30, 40.
    localparam t_tgt_tab HIGH_TARGET = '{
        12'((18800 - 164 * 53) / 10),
        12'((18800 - 164 * 40) / 10),
        12'((18800 - 164 * 40) / 10),
        12'((18800 - 164 * 45) / 10),
        12'((18800 - 164 * 40) / 10)
    };
    localparam t_tgt_tab LOW_TARGET = '{
        12'((18800 - 164 * 35) / 10),
        12'((18800 - 164 * 28) / 10),
        12'((18800 - 164 * 25) / 10),
        12'((18800 - 164 * 30) / 10),
        12'((18800 - 164 * 40) / 10)
    };

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P         = 3'd0,
        CFG_GAIN_I         = 3'd1,
        CFG_GAIN_D         = 3'd2,
        CFG_SETTLE_BAND    = 3'd3,
        CFG_SETTLE_TIMEOUT = 3'd4,
        CFG_TARGET_MIN     = 3'd5,
        CFG_TARGET_MAX     = 3'd6
    } t_cfg_idx;

    // Configuration reset values
    localparam logic [GAIN_W-1:0]    RST_GAIN_P         = 24'd26214;
    localparam logic [GAIN_W-1:0]    RST_GAIN_I         = 24'd262;
    localparam logic [GAIN_W-1:0]    RST_GAIN_D         = 24'd0;
    localparam logic [READING_W-1:0] RST_SETTLE_BAND    = 12'd20;
    localparam logic [CNT_W-1:0]     RST_SETTLE_TIMEOUT = 16'd200;
    localparam logic [READING_W-1:0] RST_TARGET_MIN     = 12'd1000;
    localparam logic [READING_W-1:0] RST_TARGET_MAX     = 12'd1370;

    // Sample word handed from the loop state logic to the drive pipeline
    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [SUM_W-1:0]  sum;
        logic signed [DIFF_W-1:0] diff;
        logic                     settled;
        logic [READING_W-1:0]     target;
    } t_sample;

    // Fields that ride along the pipeline unchanged
    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic                    settled;
        logic [READING_W-1:0]    target;
    } t_tag;

    // Result word leaving the drive pipeline
    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        t_tag                      tag;
    } t_result;

endpackage

// ===== design/ppid_drive_pipe.sv =====
// Drive pipeline of the preset position PID loop: gain multiplies, integral
// term clamp, sum, negation and saturation, with a stall-able output register.
// Depends on ppid_pkg.
module ppid_drive_pipe (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [ppid_pkg::GAIN_W-1:0]    i_gain_p,
    input  logic [ppid_pkg::GAIN_W-1:0]    i_gain_i,
    input  logic [ppid_pkg::GAIN_W-1:0]    i_gain_d,
    input  logic                           i_vld,
    output logic                           o_rdy,
    input  ppid_pkg::t_sample              i_smp,
    output logic                           o_vld,
    input  logic                           i_rdy,
    output ppid_pkg::t_result              o_res
);

    localparam int PT_W  = 37;   // gain_p * err
    localparam int DT_W  = 38;   // gain_d * diff
    localparam int PLO_W = 44;   // gain_i * low half of sum
    localparam int PHI_W = 45;   // gain_i * high half of sum
    localparam int IF_W  = 65;   // full integral product
    localparam int IT_W  = 42;   // clamped integral term
    localparam int TOT_W = 43;
    localparam int NEG_W = 44;
    localparam int HALF  = 20;

    localparam logic signed [IF_W-1:0]  I_LIM    = 65'sh100_0000_0000;
    localparam logic signed [NEG_W-1:0] Q_BIAS   = 44'sd65535;
    localparam logic signed [NEG_W-1:0] DRV_MAX  = 44'sd32767;
    localparam logic signed [NEG_W-1:0] DRV_MIN  = -44'sd32768;

    // Stage valids and enables; a stage moves when it is empty or the next one moves
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;

    assign en5   = !r_v5 || i_rdy;
    assign en4   = !r_v4 || en5;
    assign en3   = !r_v3 || en4;
    assign en2   = !r_v2 || en3;
    assign en1   = !r_v1 || en2;
    assign o_rdy = en1;
    assign o_vld = r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_vld;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // Stage 1: sample word register
    ppid_pkg::t_sample r_s1;

    always_ff @(posedge i_clk) begin
        if (en1) r_s1 <= i_smp;
    end

    // Stage 2: the three gain products, integral split in two halves
    logic signed [PT_W-1:0]  r_pterm2, n_pterm2;
    logic signed [DT_W-1:0]  r_dterm2, n_dterm2;
    logic [PLO_W-1:0]        r_plo2, n_plo2;
    logic signed [PHI_W-1:0] r_phi2, n_phi2;
    ppid_pkg::t_tag          r_tag2, r_tag3, r_tag4;

    always_comb begin
        n_pterm2 = PT_W'($signed({1'b0, i_gain_p})) * PT_W'(r_s1.err);
        n_dterm2 = DT_W'($signed({1'b0, i_gain_d})) * DT_W'(r_s1.diff);
        n_plo2   = PLO_W'(i_gain_i) * PLO_W'(r_s1.sum[HALF-1:0]);
        n_phi2   = PHI_W'($signed({1'b0, i_gain_i}))
                   * PHI_W'($signed(r_s1.sum[ppid_pkg::SUM_W-1:HALF]));
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_pterm2 <= n_pterm2;
            r_dterm2 <= n_dterm2;
            r_plo2   <= n_plo2;
            r_phi2   <= n_phi2;
            r_tag2   <= '{err: r_s1.err, settled: r_s1.settled, target: r_s1.target};
        end
    end

    // Stage 3: join the integral halves and clamp to plus or minus 2^40
    logic signed [IF_W-1:0] ifull;
    logic signed [IT_W-1:0] r_iterm3, n_iterm3;
    logic signed [PT_W-1:0] r_pterm3;
    logic signed [DT_W-1:0] r_dterm3;

    always_comb begin
        ifull = (IF_W'(r_phi2) <<< HALF) + $signed({{(IF_W - PLO_W){1'b0}}, r_plo2});
        if (ifull > I_LIM) begin
            n_iterm3 = IT_W'(I_LIM);
        end else if (ifull < -I_LIM) begin
            n_iterm3 = IT_W'(-I_LIM);
        end else begin
            n_iterm3 = IT_W'(ifull);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_iterm3 <= n_iterm3;
            r_pterm3 <= r_pterm2;
            r_dterm3 <= r_dterm2;
            r_tag3   <= r_tag2;
        end
    end

    // Stage 4: total of the three terms
    logic signed [TOT_W-1:0] r_total4, n_total4;

    assign n_total4 = TOT_W'(r_pterm3) + TOT_W'(r_iterm3) + TOT_W'(r_dterm3);

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_total4 <= n_total4;
            r_tag4   <= r_tag3;
        end
    end

    // Stage 5: negate, divide by 2^16 toward zero, saturate to 16 bits
    logic signed [NEG_W-1:0]              neg, biased, quot;
    logic signed [ppid_pkg::DRIVE_W-1:0]  n_drive;
    ppid_pkg::t_result                    r_res;

    always_comb begin
        neg    = -NEG_W'(r_total4);
        biased = (neg < 0) ? neg + Q_BIAS : neg;
        quot   = biased >>> 16;
        if (quot > DRV_MAX) begin
            n_drive = ppid_pkg::DRIVE_W'(DRV_MAX);
        end else if (quot < DRV_MIN) begin
            n_drive = ppid_pkg::DRIVE_W'(DRV_MIN);
        end else begin
            n_drive = quot[ppid_pkg::DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_res.drive <= n_drive;
            r_res.tag   <= r_tag4;
        end
    end

    assign o_res = r_res;

endmodule

// ===== design/preset_position_pid_top.sv =====
// Top level of the preset position PID loop: configuration registers, loop
// state (target, integral, last error, sample count) and stream ports.
// Depends on ppid_pkg and ppid_drive_pipe.
// Throughput: one word per cycle on the input stream while the output stream is not stalled; move words give no result.
// Result path: a sample's result word passes the five register stages of the drive pipeline
// (sample, multiply, clamp, sum, saturate) before it is shown on the output stream.
// Reset (synchronous, active low) clears the loop state and pipeline valids and loads
// the configuration defaults; no clearing pass is needed.
module preset_position_pid_top #(
    parameter int PRESET_COUNT = ppid_pkg::PRESET_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // reading[11:0], preset_index[14:12], zero[15]
    input  logic [1:0]  s_axis_tuser,   // cmd[0], high_set[1]
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // drive[15:0], error_out[28:16], settled[29],
                                        // target_out[41:30], zero[47:42]
);

    localparam int RW = ppid_pkg::READING_W;
    localparam int EW = ppid_pkg::ERR_W;
    localparam int SW = ppid_pkg::SUM_W;
    localparam int CW = ppid_pkg::CNT_W;
    localparam int GW = ppid_pkg::GAIN_W;

    // Entries in use never exceed the table length; larger indexes take the last one
    localparam int PRESET_USED = (PRESET_COUNT > ppid_pkg::PRESET_TABLE_LEN) ?
                                 ppid_pkg::PRESET_TABLE_LEN : PRESET_COUNT;
    localparam logic [2:0] PRESET_LAST = 3'(PRESET_USED - 1);

    // Configuration registers
    logic [GW-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic [RW-1:0] r_settle_band, r_target_min, r_target_max;
    logic [CW-1:0] r_settle_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p         <= ppid_pkg::RST_GAIN_P;
            r_gain_i         <= ppid_pkg::RST_GAIN_I;
            r_gain_d         <= ppid_pkg::RST_GAIN_D;
            r_settle_band    <= ppid_pkg::RST_SETTLE_BAND;
            r_settle_timeout <= ppid_pkg::RST_SETTLE_TIMEOUT;
            r_target_min     <= ppid_pkg::RST_TARGET_MIN;
            r_target_max     <= ppid_pkg::RST_TARGET_MAX;
        end else if (i_cfg_we) begin
            case (ppid_pkg::t_cfg_idx'(i_cfg_index))
                ppid_pkg::CFG_GAIN_P:         r_gain_p         <= i_cfg_data;
                ppid_pkg::CFG_GAIN_I:         r_gain_i         <= i_cfg_data;
                ppid_pkg::CFG_GAIN_D:         r_gain_d         <= i_cfg_data;
                ppid_pkg::CFG_SETTLE_BAND:    r_settle_band    <= i_cfg_data[RW-1:0];
                ppid_pkg::CFG_SETTLE_TIMEOUT: r_settle_timeout <= i_cfg_data[CW-1:0];
                ppid_pkg::CFG_TARGET_MIN:     r_target_min     <= i_cfg_data[RW-1:0];
                ppid_pkg::CFG_TARGET_MAX:     r_target_max     <= i_cfg_data[RW-1:0];
                default: ;
            endcase
        end
    end

    // Input word fields
    logic          in_cmd, in_high_set, in_accept;
    logic [RW-1:0] in_reading;
    logic [2:0]    in_index;

    assign in_cmd      = s_axis_tuser[0];
    assign in_high_set = s_axis_tuser[1];
    assign in_reading  = s_axis_tdata[RW-1:0];
    assign in_index    = s_axis_tdata[14:12];
    assign in_accept   = s_axis_tvalid && s_axis_tready;

    // Loop state
    logic [RW-1:0]        r_target, n_target;
    logic signed [SW-1:0] r_sum, n_sum;
    logic signed [EW-1:0] r_prev_err;
    logic [CW-1:0]        r_count, n_count;

    // Move: preset lookup and clamp, max test first
    logic [2:0]    idx_c;
    logic [RW-1:0] tgt_raw;

    always_comb begin
        idx_c   = (in_index > PRESET_LAST) ? PRESET_LAST : in_index;
        tgt_raw = in_high_set ? ppid_pkg::HIGH_TARGET[idx_c] : ppid_pkg::LOW_TARGET[idx_c];
        if (tgt_raw > r_target_max) begin
            n_target = r_target_max;
        end else if (tgt_raw < r_target_min) begin
            n_target = r_target_min;
        end else begin
            n_target = tgt_raw;
        end
    end

    // Sample: error, saturating integral, difference, sample count, settled flag
    logic signed [EW-1:0]   err;
    logic signed [SW:0]     sum_wide;
    logic [EW-1:0]          abs_err;
    ppid_pkg::t_sample      smp;

    always_comb begin
        err      = $signed({1'b0, in_reading}) - $signed({1'b0, r_target});
        sum_wide = (SW + 1)'(r_sum) + (SW + 1)'(err);
        if (sum_wide[SW] != sum_wide[SW-1]) begin
            n_sum = sum_wide[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
        end else begin
            n_sum = sum_wide[SW-1:0];
        end
        n_count     = (r_count == {CW{1'b1}}) ? r_count : r_count + 1'b1;
        abs_err     = err[EW-1] ? -err : err;
        smp.err     = err;
        smp.sum     = n_sum;
        smp.diff    = ppid_pkg::DIFF_W'(err) - ppid_pkg::DIFF_W'(r_prev_err);
        smp.settled = (abs_err < {1'b0, r_settle_band}) || (n_count > r_settle_timeout);
        smp.target  = r_target;
    end

    // State update on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= '0;
            r_sum      <= '0;
            r_prev_err <= '0;
            r_count    <= '0;
        end else if (in_accept) begin
            if (in_cmd) begin
                r_target <= n_target;
                r_sum    <= '0;
                r_count  <= '0;
            end else begin
                r_sum      <= n_sum;
                r_prev_err <= err;
                r_count    <= n_count;
            end
        end
    end

    // Drive pipeline; only sample words enter it
    ppid_pkg::t_result res;

    ppid_drive_pipe u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_gain_p (r_gain_p),
        .i_gain_i (r_gain_i),
        .i_gain_d (r_gain_d),
        .i_vld    (s_axis_tvalid && !in_cmd),
        .o_rdy    (s_axis_tready),
        .i_smp    (smp),
        .o_vld    (m_axis_tvalid),
        .i_rdy    (m_axis_tready),
        .o_res    (res)
    );

    assign m_axis_tdata = {6'b0, res.tag.target, res.tag.settled, res.tag.err, res.drive};

endmodule

// ===== design/ppid_checker.sv =====
// Port checker for the preset position PID loop, bound to the top level.
// Depends on preset_position_pid_top.
module ppid_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output word valid right after reset");

    // A stalled output word holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

    // With the output register empty the pipeline has room for a word.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready while output is empty");

    // Padding bits stay zero and the error never reaches its most negative code.
    a_word_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[47:42] == 6'b0 && m_axis_tdata[28:16] != 13'h1000)
        else $error("output word out of range");

endmodule

bind preset_position_pid_top ppid_checker u_ppid_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
